@@ rtl/pspdt_pkg.sv @@
// Package for the Proth small-prime divisibility test core.
// Holds the item structs, the sequencer state type and the width constants.
// No dependencies.
package pspdt_pkg;

   localparam int PRIME_BITS = 15;
   localparam int K_W        = 64;
   localparam int N_W        = 32;
   localparam int P_W        = 15;
   localparam int MUL_W      = 16;

   localparam logic [P_W-1:0] PRIME_MASK = P_W'((1 << PRIME_BITS) - 1);

   typedef struct packed {
      logic [K_W-1:0] multiplier;
      logic [N_W-1:0] exponent;
      logic [P_W-1:0] prime;
   } req_type;

   typedef struct packed {
      logic           divides;
      logic [P_W-1:0] inverse_power;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KMOD,
      ST_NS_PX,
      ST_NS_XD,
      ST_NS_UPD,
      ST_NORM,
      ST_SEED,
      ST_SQ_T,
      ST_SQ_M,
      ST_SQ_P,
      ST_SQ_SUM,
      ST_HALF,
      ST_FIN
   } state_type;

endpackage

@@ rtl/proth_small_prime_divisibility_test_core.sv @@
// Proth small-prime divisibility test core: 2^-N mod p by Montgomery power,
// negated when plus_form is 1, compared against K mod p. One shared 16x16
// multiplier is used under a sequencer. Depends on pspdt_pkg.
//
//   channel | ports                          | item
//   --------+--------------------------------+----------------------------------
//   request | req_valid, req_stall, req_item | multiplier, exponent, prime
//   result  | rsp_valid, rsp_stall, rsp_item | divides, inverse_power
//   config  | csr_valid, csr_ready, csr_data | plus_form
//
// One item at a time: the core reduces K mod p, derives -p^-1 mod 2^16, finds
// the top exponent bit, builds the seed, runs a Montgomery square per lower
// exponent bit (and a halving where it is set), then the exit REDC, and loads
// the result before the next item is accepted.
// Reset is synchronous and sets plus_form to 1. A result waits in the output
// register under rsp_stall while the next item is already accepted.
module proth_small_prime_divisibility_test_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pspdt_pkg::req_type  req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pspdt_pkg::rsp_type  rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);

   pspdt_pkg::state_type state_ff, state_in;

   logic [pspdt_pkg::K_W-1:0]   k_ff, k_in;
   logic [pspdt_pkg::N_W-1:0]   nsh_ff, nsh_in;
   logic [pspdt_pkg::P_W-1:0]   p_ff, p_in;
   logic                        bad_ff, bad_in;
   logic                        small_ff, small_in;
   logic [pspdt_pkg::P_W-1:0]   kmod_ff, kmod_in;
   logic [5:0]                  kcnt_ff, kcnt_in;
   logic [pspdt_pkg::MUL_W-1:0] x_ff, x_in;
   logic                        iter_ff, iter_in;
   logic [pspdt_pkg::MUL_W-1:0] ns_ff, ns_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [4:0]                  dbl_ff, dbl_in;
   logic [pspdt_pkg::P_W-1:0]   r_ff, r_in;
   logic [2*pspdt_pkg::MUL_W-1:0] t_ff, t_in;
   logic [2*pspdt_pkg::MUL_W-1:0] prod_ff, prod_in;
   logic                        final_ff, final_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pspdt_pkg::rsp_type          rsp_item_ff, rsp_item_in;
   logic                        plus_form_ff;

   logic [pspdt_pkg::MUL_W-1:0] mul_a, mul_b;
   logic [pspdt_pkg::MUL_W-1:0] rem2, dbl2, tp, half_sum;
   logic [pspdt_pkg::MUL_W:0]   u_sum;
   logic [pspdt_pkg::P_W-1:0]   p_req, v_out;

   assign req_stall = (state_ff != pspdt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;
   assign p_req     = req_item.prime & pspdt_pkg::PRIME_MASK;
   assign prod_in   = (2*pspdt_pkg::MUL_W)'(mul_a) * (2*pspdt_pkg::MUL_W)'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pspdt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         plus_form_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            plus_form_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      nsh_ff      <= nsh_in;
      p_ff        <= p_in;
      bad_ff      <= bad_in;
      small_ff    <= small_in;
      kmod_ff     <= kmod_in;
      kcnt_ff     <= kcnt_in;
      x_ff        <= x_in;
      iter_ff     <= iter_in;
      ns_ff       <= ns_in;
      cnt_ff      <= cnt_in;
      dbl_ff      <= dbl_in;
      r_ff        <= r_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      final_ff    <= final_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      nsh_in       = nsh_ff;
      p_in         = p_ff;
      bad_in       = bad_ff;
      small_in     = small_ff;
      kmod_in      = kmod_ff;
      kcnt_in      = kcnt_ff;
      x_in         = x_ff;
      iter_in      = iter_ff;
      ns_in        = ns_ff;
      cnt_in       = cnt_ff;
      dbl_in       = dbl_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      final_in     = final_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;

      rem2     = {kmod_ff, k_ff[pspdt_pkg::K_W-1]};
      dbl2     = {r_ff, 1'b0};
      tp       = {1'b0, p_ff} + {p_ff, 1'b0};
      half_sum = {1'b0, r_ff} + (r_ff[0] ? {1'b0, p_ff} : '0);
      u_sum    = {1'b0, t_ff[31:16]} + {1'b0, prod_ff[31:16]}
                 + {16'd0, (t_ff[15:0] != 16'd0)};
      v_out    = plus_form_ff ? (p_ff - r_ff) : r_ff;

      unique case (state_ff)
         pspdt_pkg::ST_IDLE: begin
            if (req_valid) begin
               k_in     = req_item.multiplier;
               nsh_in   = req_item.exponent;
               p_in     = p_req;
               bad_in   = (p_req < 15'd3) || !p_req[0];
               small_in = (req_item.exponent < 32'd16);
               kmod_in  = '0;
               kcnt_in  = '0;
               r_in     = 15'd1;
               cnt_in   = 5'd28;
               state_in = ((p_req < 15'd3) || !p_req[0]) ? pspdt_pkg::ST_FIN
                                                          : pspdt_pkg::ST_KMOD;
            end
         end
         pspdt_pkg::ST_KMOD: begin
            kmod_in = (rem2 >= {1'b0, p_ff}) ? 15'(rem2 - {1'b0, p_ff}) : 15'(rem2);
            k_in    = {k_ff[pspdt_pkg::K_W-2:0], 1'b0};
            kcnt_in = kcnt_ff + 6'd1;
            if (kcnt_ff == 6'd63) begin
               x_in     = tp ^ 16'd2;
               iter_in  = 1'b0;
               state_in = pspdt_pkg::ST_NS_PX;
            end
         end
         pspdt_pkg::ST_NS_PX: begin
            mul_a    = {1'b0, p_ff};
            mul_b    = x_ff;
            state_in = pspdt_pkg::ST_NS_XD;
         end
         pspdt_pkg::ST_NS_XD: begin
            mul_a    = x_ff;
            mul_b    = 16'd2 - prod_ff[15:0];
            state_in = pspdt_pkg::ST_NS_UPD;
         end
         pspdt_pkg::ST_NS_UPD: begin
            x_in = prod_ff[15:0];
            if (iter_ff) begin
               ns_in    = 16'd0 - prod_ff[15:0];
               state_in = pspdt_pkg::ST_NORM;
            end else begin
               iter_in  = 1'b1;
               state_in = pspdt_pkg::ST_NS_PX;
            end
         end
         pspdt_pkg::ST_NORM: begin
            priority if (small_ff) begin
               dbl_in   = 5'd16 - {1'b0, nsh_ff[3:0]};
               cnt_in   = '0;
               state_in = pspdt_pkg::ST_SEED;
            end else if (nsh_ff[31]) begin
               dbl_in   = 5'd16 - {1'b0, nsh_ff[31:28]};
               state_in = pspdt_pkg::ST_SEED;
            end else begin
               nsh_in = {nsh_ff[30:0], 1'b0};
               cnt_in = cnt_ff - 5'd1;
            end
         end
         pspdt_pkg::ST_SEED: begin
            r_in   = (dbl2 >= {1'b0, p_ff}) ? 15'(dbl2 - {1'b0, p_ff}) : 15'(dbl2);
            dbl_in = dbl_ff - 5'd1;
            if (dbl_ff == 5'd1) begin
               final_in = (cnt_ff == 5'd0);
               state_in = pspdt_pkg::ST_SQ_T;
            end
         end
         pspdt_pkg::ST_SQ_T: begin
            mul_a    = {1'b0, r_ff};
            mul_b    = final_ff ? 16'd1 : {1'b0, r_ff};
            state_in = pspdt_pkg::ST_SQ_M;
         end
         pspdt_pkg::ST_SQ_M: begin
            t_in     = prod_ff;
            mul_a    = prod_ff[15:0];
            mul_b    = ns_ff;
            state_in = pspdt_pkg::ST_SQ_P;
         end
         pspdt_pkg::ST_SQ_P: begin
            mul_a    = prod_ff[15:0];
            mul_b    = {1'b0, p_ff};
            state_in = pspdt_pkg::ST_SQ_SUM;
         end
         pspdt_pkg::ST_SQ_SUM: begin
            r_in = (u_sum >= {2'b0, p_ff}) ? 15'(u_sum - {2'b0, p_ff}) : 15'(u_sum);
            if (final_ff) begin
               state_in = pspdt_pkg::ST_FIN;
            end else begin
               nsh_in   = {nsh_ff[30:0], 1'b0};
               cnt_in   = cnt_ff - 5'd1;
               final_in = (cnt_ff == 5'd1);
               state_in = nsh_ff[27] ? pspdt_pkg::ST_HALF : pspdt_pkg::ST_SQ_T;
            end
         end
         pspdt_pkg::ST_HALF: begin
            r_in     = half_sum[15:1];
            state_in = pspdt_pkg::ST_SQ_T;
         end
         pspdt_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (bad_ff) begin
                  rsp_item_in.divides       = 1'b0;
                  rsp_item_in.inverse_power = '0;
               end else begin
                  rsp_item_in.divides       = (v_out == kmod_ff);
                  rsp_item_in.inverse_power = v_out;
               end
               state_in = pspdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pspdt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
